// File: rtl/gbf_pkg.sv
// Shared constants, types and command codes for the graph bridge finder.
`timescale 1ns / 1ps
`default_nettype none
package gbf_pkg;

   localparam int VERTICES = 32;
   localparam int VIDX_W   = $clog2(VERTICES);
   localparam int VPTR_W   = VIDX_W + 1;          // vertex index plus a "none"/end bit
   localparam int STAMP_W  = VIDX_W + 1;          // stamps run 1..VERTICES
   localparam int SCAN_W   = 2 * VIDX_W + 1;      // {done, parent, child}
   localparam int TDATA_W  = ((2 * VIDX_W + 7) / 8) * 8;

   typedef logic [VIDX_W-1:0]  vidx_type;
   typedef logic [VPTR_W-1:0]  vptr_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [SCAN_W-1:0]  scan_type;

   localparam vptr_type PARENT_NONE = vptr_type'(1) << VIDX_W;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_A,
      OP_LOAD_B,
      OP_ROOT_SKIP,
      OP_ROOT_OPEN,
      OP_SCAN_SKIP,
      OP_SCAN_BACK,
      OP_DESCEND,
      OP_POP,
      OP_EMIT_SKIP,
      OP_EMIT_HOLD,
      OP_EMIT_SEND,
      OP_EMIT_LAST,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LOAD_B,
      ST_ROOT,
      ST_SCAN,
      ST_EMIT,
      ST_FLUSH,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      op_type op;
      logic   emit_sel;   // steer the parent read port to the emission scan
   } cmd_type;

   typedef struct packed {
      logic edge_last;
      logic root_end;
      logic root_vis;
      logic n_end;
      logic adj_bit;
      logic nbr_vis;
      logic nbr_par;
      logic par_none;
      logic emit_end;
      logic emit_match;
      logic has_pend;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/graph_bridge_finder.sv
// Top level of the graph bridge finder: edge loader, depth-first bridge walk, result stream.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata: end_a, end_b; tlast: final_edge
//   rsp      out  rsp_tvalid/tready    tdata: parent_vertex, child_vertex;
//                                      tuser: found; tlast: end_of_run
//
// Each edge word is written one matrix bit per cycle (row a, then row b).
// After the final edge the walk scans every row bit by bit, one neighbour per
// cycle; the result scan then walks all parent/child pairs, the flush state
// sends the last word and the clear state clears the store. req_tready is low
// from the final edge until then.
// Reset clears the matrix, visited and mark bits and parent table at once; no clearing pass is needed.
// A stalled rsp side only holds the result scan; a finished word waits in the
// output register while the next bridge is held in a one-word pending stage.
`timescale 1ns / 1ps
`default_nettype none
module graph_bridge_finder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [4:0] end_a, [9:5] end_b, rest zero
   input  wire         req_tlast,    // final_edge
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,    // [4:0] parent_vertex, [9:5] child_vertex, rest zero
   output logic        rsp_tuser,    // found
   output logic        rsp_tlast     // end_of_run
);
   import gbf_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;
   vidx_type   parent_vertex, child_vertex;

   gbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   gbf_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .end_a         (req_tdata[VIDX_W-1:0]),
      .end_b         (req_tdata[2*VIDX_W-1:VIDX_W]),
      .final_edge    (req_tlast),
      .cmd           (cmd),
      .status        (status),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .parent_vertex (parent_vertex),
      .child_vertex  (child_vertex),
      .found         (rsp_tuser),
      .end_of_run    (rsp_tlast)
   );

   // zero padding above the two vertex fields
   assign rsp_tdata = TDATA_W'({child_vertex, parent_vertex});

`ifndef ASSERT_OFF
   // a no-bridge word is always the only and last word of its graph
   a_nobridge_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("no-bridge word without end_of_run");

   // a bridge never joins a vertex to itself
   a_bridge_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4:0] != rsp_tdata[9:5])
      else $error("bridge with equal endpoints");

   // the final edge stops intake until the graph is done
   a_final_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("intake open right after final edge");

   // intake only while no walk or result scan is under way
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state == ST_LOAD && !status.has_pend)
      else $error("intake during walk");
`endif

endmodule
`default_nettype wire

// File: rtl/gbf_ctrl.sv
// Controller state machine for the graph bridge finder.
`timescale 1ns / 1ps
`default_nettype none
module gbf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  gbf_pkg::status_type  status,
   output gbf_pkg::cmd_type     cmd,
   output gbf_pkg::state_type   state
);
   import gbf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.emit_sel = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD_A;
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            cmd.op   = OP_LOAD_B;
            state_in = status.edge_last ? ST_ROOT : ST_LOAD;
         end
         ST_ROOT: begin
            if (status.root_end) begin
               state_in = ST_EMIT;
            end else if (status.root_vis) begin
               cmd.op = OP_ROOT_SKIP;
            end else begin
               cmd.op   = OP_ROOT_OPEN;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.n_end) begin
               if (status.par_none) begin
                  state_in = ST_ROOT;
               end else begin
                  cmd.op = OP_POP;
               end
            end else if (!status.adj_bit) begin
               cmd.op = OP_SCAN_SKIP;
            end else if (!status.nbr_vis) begin
               cmd.op = OP_DESCEND;
            end else if (!status.nbr_par) begin
               cmd.op = OP_SCAN_BACK;
            end else begin
               cmd.op = OP_SCAN_SKIP;
            end
         end
         ST_EMIT: begin
            cmd.emit_sel = 1'b1;
            if (status.emit_end) begin
               state_in = ST_FLUSH;
            end else if (!status.emit_match) begin
               cmd.op = OP_EMIT_SKIP;
            end else if (!status.has_pend) begin
               cmd.op = OP_EMIT_HOLD;
            end else if (status.out_free) begin
               cmd.op = OP_EMIT_SEND;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_LAST;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.op   = OP_CLEAR;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign state = state_ff;

endmodule
`default_nettype wire

// File: rtl/gbf_dpath.sv
// Datapath: adjacency matrix, walk registers, per-vertex tables and result register.
`timescale 1ns / 1ps
`default_nettype none
module gbf_dpath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [gbf_pkg::VIDX_W-1:0]    end_a,
   input  wire [gbf_pkg::VIDX_W-1:0]    end_b,
   input  wire                          final_edge,
   input  gbf_pkg::cmd_type             cmd,
   output gbf_pkg::status_type          status,
   input  wire                          rsp_tready,
   output logic                         rsp_tvalid,
   output logic [gbf_pkg::VIDX_W-1:0]   parent_vertex,
   output logic [gbf_pkg::VIDX_W-1:0]   child_vertex,
   output logic                         found,
   output logic                         end_of_run
);
   import gbf_pkg::*;

   logic [VERTICES-1:0] adj_ff [VERTICES];
   logic [VERTICES-1:0] visited_ff;
   logic [VERTICES-1:0] mark_ff;
   vptr_type            parent_ff [VERTICES];
   stamp_type           disc_ff   [VERTICES];
   stamp_type           low_ff    [VERTICES];

   vidx_type  a_ff, b_ff;
   logic      last_ff;
   vidx_type  cur_v_ff;
   vptr_type  cur_n_ff;
   vptr_type  cur_par_ff;
   stamp_type cur_low_ff;
   stamp_type stamp_ff;
   vptr_type  root_ff;
   scan_type  scan_ff;
   logic      pend_ff;
   vidx_type  pend_p_ff, pend_c_ff;
   logic      valid_ff;
   vidx_type  out_p_ff, out_c_ff;
   logic      out_found_ff, out_eor_ff;

   vidx_type  nbr, par_v, scan_p, scan_c, par_addr, disc_addr;
   vptr_type  par_rd;
   stamp_type disc_rd, low_p, new_low, stamp_in;
   logic      out_free;

   assign nbr       = cur_n_ff[VIDX_W-1:0];
   assign par_v     = cur_par_ff[VIDX_W-1:0];
   assign scan_c    = scan_ff[VIDX_W-1:0];
   assign scan_p    = scan_ff[2*VIDX_W-1:VIDX_W];
   assign par_addr  = cmd.emit_sel ? scan_c : par_v;
   assign par_rd    = parent_ff[par_addr];
   assign disc_addr = (cmd.op == OP_POP) ? par_v : nbr;
   assign disc_rd   = disc_ff[disc_addr];
   assign low_p     = low_ff[par_v];
   assign new_low   = (cur_low_ff < low_p) ? cur_low_ff : low_p;
   assign stamp_in  = stamp_type'(stamp_ff + 1'b1);
   assign out_free  = !valid_ff || rsp_tready;

   always_comb begin
      status.edge_last  = last_ff;
      status.root_end   = root_ff[VIDX_W];
      status.root_vis   = visited_ff[root_ff[VIDX_W-1:0]];
      status.n_end      = cur_n_ff[VIDX_W];
      status.adj_bit    = adj_ff[cur_v_ff][nbr];
      status.nbr_vis    = visited_ff[nbr];
      status.nbr_par    = ({1'b0, nbr} == cur_par_ff);
      status.par_none   = cur_par_ff[VIDX_W];
      status.emit_end   = scan_ff[SCAN_W-1];
      status.emit_match = mark_ff[scan_c] && (par_rd == {1'b0, scan_p});
      status.has_pend   = pend_ff;
      status.out_free   = out_free;
   end

   // walk and table state
   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_CLEAR) begin
         for (int i = 0; i < VERTICES; i++) begin
            adj_ff[i]    <= '0;
            parent_ff[i] <= PARENT_NONE;
         end
         visited_ff <= '0;
         mark_ff    <= '0;
         stamp_ff   <= '0;
         root_ff    <= '0;
         scan_ff    <= '0;
         pend_ff    <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD_A: begin
               a_ff             <= end_a;
               b_ff             <= end_b;
               last_ff          <= final_edge;
               adj_ff[end_a][end_b] <= 1'b1;
            end
            OP_LOAD_B: begin
               adj_ff[b_ff][a_ff] <= 1'b1;
            end
            OP_ROOT_SKIP: begin
               root_ff <= vptr_type'(root_ff + 1'b1);
            end
            OP_ROOT_OPEN: begin
               stamp_ff                          <= stamp_in;
               disc_ff[root_ff[VIDX_W-1:0]]      <= stamp_in;
               low_ff[root_ff[VIDX_W-1:0]]       <= stamp_in;
               visited_ff[root_ff[VIDX_W-1:0]]   <= 1'b1;
               cur_v_ff                          <= root_ff[VIDX_W-1:0];
               cur_n_ff                          <= '0;
               cur_low_ff                        <= stamp_in;
               cur_par_ff                        <= PARENT_NONE;
            end
            OP_SCAN_SKIP: begin
               cur_n_ff <= vptr_type'(cur_n_ff + 1'b1);
            end
            OP_SCAN_BACK: begin
               if (disc_rd < cur_low_ff) begin
                  cur_low_ff       <= disc_rd;
                  low_ff[cur_v_ff] <= disc_rd;
               end
               cur_n_ff <= vptr_type'(cur_n_ff + 1'b1);
            end
            OP_DESCEND: begin
               stamp_ff        <= stamp_in;
               disc_ff[nbr]    <= stamp_in;
               low_ff[nbr]     <= stamp_in;
               visited_ff[nbr] <= 1'b1;
               parent_ff[nbr]  <= {1'b0, cur_v_ff};
               cur_par_ff      <= {1'b0, cur_v_ff};
               cur_v_ff        <= nbr;
               cur_n_ff        <= '0;
               cur_low_ff      <= stamp_in;
            end
            OP_POP: begin
               // child finished: fold its low link into the parent, resume after it
               low_ff[par_v] <= new_low;
               if (cur_low_ff > disc_rd) begin
                  mark_ff[cur_v_ff] <= 1'b1;
               end
               cur_low_ff <= new_low;
               cur_par_ff <= par_rd;
               cur_v_ff   <= par_v;
               cur_n_ff   <= vptr_type'({1'b0, cur_v_ff} + 1'b1);
            end
            OP_EMIT_SKIP: begin
               scan_ff <= scan_type'(scan_ff + 1'b1);
            end
            OP_EMIT_HOLD: begin
               pend_ff   <= 1'b1;
               pend_p_ff <= scan_p;
               pend_c_ff <= scan_c;
               scan_ff   <= scan_type'(scan_ff + 1'b1);
            end
            OP_EMIT_SEND: begin
               pend_p_ff <= scan_p;
               pend_c_ff <= scan_c;
               scan_ff   <= scan_type'(scan_ff + 1'b1);
            end
            OP_EMIT_LAST: begin
               pend_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT_SEND || cmd.op == OP_EMIT_LAST) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT_SEND) begin
         out_p_ff     <= pend_p_ff;
         out_c_ff     <= pend_c_ff;
         out_found_ff <= 1'b1;
         out_eor_ff   <= 1'b0;
      end else if (cmd.op == OP_EMIT_LAST) begin
         out_p_ff     <= pend_ff ? pend_p_ff : '0;
         out_c_ff     <= pend_ff ? pend_c_ff : '0;
         out_found_ff <= pend_ff;
         out_eor_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign parent_vertex = out_p_ff;
   assign child_vertex  = out_c_ff;
   assign found         = out_found_ff;
   assign end_of_run    = out_eor_ff;

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench for the graph bridge finder: directed and random graphs against a bridge predictor.
`timescale 1ns / 1ps
module tb_top;
   import gbf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      vidx_type parent_vertex;
      vidx_type child_vertex;
      logic     found;
      logic     end_of_run;
   } bridge_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // predictor state: adjacency matrix of the graph being loaded
   logic [VERTICES-1:0] adj_rows [VERTICES];
   bridge_word_type     bridges_due [$];
   int                  error_count;
   int                  idle_cycles;

   graph_bridge_finder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   task automatic queue_word(input bridge_word_type w);
      bridges_due.insert(bridges_due.size(), w);
   endtask

   // Iterative DFS with low links; queues bridge words in parent/child order.
   task automatic predict_bridges();
      int   disc [VERTICES];
      int   lowv [VERTICES];
      int   par  [VERTICES];
      int   colour [VERTICES];
      int   stk_v [VERTICES];
      int   stk_n [VERTICES];
      logic mark [VERTICES];
      int   sp, stamp, v, n, p, cnt;
      bridge_word_type w;
      stamp = 0;
      cnt = 0;
      for (int i = 0; i < VERTICES; i++) begin
         colour[i] = 0; par[i] = -1; mark[i] = 1'b0; disc[i] = 0; lowv[i] = 0;
      end
      for (int r = 0; r < VERTICES; r++) begin
         if (colour[r] == 0) begin
            stamp++; disc[r] = stamp; lowv[r] = stamp; colour[r] = 1;
            sp = 1; stk_v[0] = r; stk_n[0] = 0;
            while (sp > 0) begin
               v = stk_v[sp-1];
               n = stk_n[sp-1];
               while (n < VERTICES && !adj_rows[v][n]) n++;
               if (n >= VERTICES) begin
                  colour[v] = 2;
                  sp--;
                  if (sp > 0) begin
                     p = stk_v[sp-1];
                     if (lowv[v] < lowv[p]) lowv[p] = lowv[v];
                     if (lowv[v] > disc[p]) mark[v] = 1'b1;
                  end
               end else begin
                  stk_n[sp-1] = n + 1;
                  if (colour[n] == 0) begin
                     par[n] = v;
                     stamp++; disc[n] = stamp; lowv[n] = stamp; colour[n] = 1;
                     stk_v[sp] = n; stk_n[sp] = 0; sp++;
                  end else if (n != par[v]) begin
                     if (disc[n] < lowv[v]) lowv[v] = disc[n];
                  end
               end
            end
         end
      end
      for (int pp = 0; pp < VERTICES; pp++)
         for (int c = 0; c < VERTICES; c++)
            if (mark[c] && par[c] == pp && cnt < 31) begin
               w.parent_vertex = vidx_type'(pp);
               w.child_vertex  = vidx_type'(c);
               w.found = 1'b1;
               w.end_of_run = 1'b0;
               queue_word(w);
               cnt++;
            end
      if (cnt == 0) begin
         w = '0;
         w.end_of_run = 1'b1;
         queue_word(w);
      end else begin
         bridges_due[$].end_of_run = 1'b1;
      end
      for (int i = 0; i < VERTICES; i++) adj_rows[i] = '0;
   endtask

   // Sends one edge word after a random gap; records it on acceptance, predicts after the final edge.
   task automatic send_edge(input int a, input int b, input bit last_edge);
      repeat ($urandom_range(0, 10)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, b[4:0], a[4:0]};
      req_tlast  = last_edge;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
      if (last_edge) predict_bridges();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (bridges_due.size() != 0) @(negedge clock);
   endtask

   // Result checker with random back-pressure; gaps of no stall now and then.
   initial begin
      bridge_word_type want;
      int              stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (bridges_due.size() == 0) begin
            report_mismatch("bridge word with nothing expected");
         end else begin
            want = bridges_due.pop_front();
            if (rsp_tdata[4:0] !== want.parent_vertex)
               report_mismatch($sformatf("parent %0d want %0d", rsp_tdata[4:0],
                                         want.parent_vertex));
            if (rsp_tdata[9:5] !== want.child_vertex)
               report_mismatch($sformatf("child %0d want %0d", rsp_tdata[9:5],
                                         want.child_vertex));
            if (rsp_tdata[15:10] !== 6'd0) report_mismatch("tdata padding not zero");
            if (rsp_tuser !== want.found)
               report_mismatch($sformatf("found %b want %b", rsp_tuser, want.found));
            if (rsp_tlast !== want.end_of_run)
               report_mismatch($sformatf("end_of_run %b want %b", rsp_tlast,
                                         want.end_of_run));
         end
      end
   end

   // Watchdog: cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_directed();
      // single edge: one bridge; self loop alone: no bridge
      send_edge(0, 1, 1);
      send_edge(5, 5, 1);
      // triangle: no bridge; doubled edge still a bridge
      send_edge(2, 3, 0);
      send_edge(3, 4, 0);
      send_edge(4, 2, 0);
      send_edge(31, 30, 0);
      send_edge(30, 31, 1);
      // path through the extremes, plus a triangle hanging off it and a lone edge
      send_edge(31, 0, 0);
      send_edge(0, 16, 0);
      send_edge(16, 17, 0);
      send_edge(17, 18, 0);
      send_edge(18, 16, 0);
      send_edge(21, 10, 1);
      wait_drained();
   endtask

   task automatic test_star();
      // 31 bridges: maximum result count
      for (int i = 1; i < 32; i++) send_edge(0, i, i == 31);
   endtask

   task automatic test_random();
      int sent, len, base, kind;
      sent = 0;
      while (sent < 56) begin
         len  = $urandom_range(1, 12);
         base = $urandom_range(0, 31);
         kind = $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            if (kind == 0)      // chain with random chords: mix of cycles and bridges
               send_edge((base + i) % 32, ($urandom_range(0, 3) == 0) ?
                         $urandom_range(0, 31) : (base + i + 1) % 32, i == len - 1);
            else if (kind == 1) // tree on a small vertex set
               send_edge((base + $urandom_range(0, i)) % 32, (base + i + 1) % 32,
                         i == len - 1);
            else
               send_edge($urandom_range(0, 31), $urandom_range(0, 31), i == len - 1);
            sent++;
         end
         if (sent > 20 && sent < 34) wait_drained();
      end
   endtask

   initial begin
      error_count = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      for (int i = 0; i < VERTICES; i++) adj_rows[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_star();
      test_random();
      wait_drained();
      repeat (50) @(negedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// File: filelist.f
rtl/gbf_pkg.sv
rtl/gbf_ctrl.sv
rtl/gbf_dpath.sv
rtl/graph_bridge_finder.sv
test/tb_top.sv
